// ----- src/rabs_pkg.sv -----
// Shared constants and types for the running-average background subtractor.
package rabs_pkg;

  // Word field widths
  localparam int ADDR_W   = 20;
  localparam int SAMPLE_W = 8;
  localparam int CNT_W    = 8;
  localparam int ALPHA_W  = 9;
  localparam int MODE_W   = 2;
  localparam int PROD_W   = 16;

  // Default frame store depth
  localparam int NUM_SAMPLES_DEF = 1048576;

  // Address reduction: compare-subtract steps per front stage
  localparam int RED_PER = 4;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [APB_AW-3:0] {
    REG_MODE    = 3'd0,
    REG_ALPHA   = 3'd1,
    REG_THRESH  = 3'd2,
    REG_SEL_UPD = 3'd3,
    REG_GHOST   = 3'd4
  } reg_idx_t;

  // Mode codes (code 3 behaves as the ghost-counter mode)
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RUNAVG = 2'd1;

  // Word kinds
  localparam logic KIND_INIT = 1'b0;
  localparam logic KIND_PROC = 1'b1;

  // Register reset values
  localparam logic [MODE_W-1:0]   MODE_RST   = MODE_PLAIN;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 9'd13;
  localparam logic [SAMPLE_W-1:0] THRESH_RST = 8'd25;
  localparam logic                SEL_RST    = 1'b0;
  localparam logic [CNT_W-1:0]    GHOST_RST  = 8'd50;

  // Arithmetic constants
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 16'd128;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 8'd255;

endpackage

// ----- src/running_average_background_subtractor.sv -----
// Running-average background subtractor: address reduction, store access and pixel pipeline.
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_ready  kind, sample_addr, sample
// out       output     out_valid/out_ready  foreground, difference, background_value
// apb       input      psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One word per cycle in steady state while no hazard wait or output stall holds the flow. A result
// passes the P0 address-wrap stages (one when the store covers the full address range, the
// first loaded by the accepting edge), store read, multiply, blend and compare, and the
// decision into the output register. A process word whose address matches a word still in
// the last three stages waits for that word's write-back, which an output stall can delay.
// Reset clears valid bits and registers; the store is not cleared, so every address needs
// an init word before it is processed. Each stage holds while the next one is full.
module running_average_background_subtractor #(
  parameter int NUM_SAMPLES = rabs_pkg::NUM_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input words
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic [rabs_pkg::ADDR_W-1:0]     sample_addr,
  input  logic [rabs_pkg::SAMPLE_W-1:0]   sample,
  // result words
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            foreground,
  output logic [rabs_pkg::SAMPLE_W-1:0]   difference,
  output logic [rabs_pkg::SAMPLE_W-1:0]   background_value,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rabs_pkg::APB_AW-1:0]     paddr,
  input  logic [rabs_pkg::APB_DW-1:0]     pwdata,
  output logic [rabs_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int AW     = rabs_pkg::ADDR_W;
  localparam int SW     = rabs_pkg::SAMPLE_W;
  localparam int CW     = rabs_pkg::CNT_W;
  localparam int PW     = rabs_pkg::PROD_W;
  localparam int DW     = rabs_pkg::APB_DW;
  localparam int RW     = AW + 1;
  localparam int IDX_W  = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam int FULL   = (NUM_SAMPLES >= (1 << AW)) ? 1 : 0;
  localparam int NSTEP  = (FULL != 0) ? 0 : (AW + 1 - $clog2(NUM_SAMPLES + 1));
  localparam int P0     = (NSTEP > 0) ?
                          (NSTEP + rabs_pkg::RED_PER - 1) / rabs_pkg::RED_PER : 1;
  localparam int L      = P0 - 1;

  // ---------------------------------------------------------------- config
  logic [rabs_pkg::MODE_W-1:0]  mode;
  logic [rabs_pkg::ALPHA_W-1:0] alpha_q8;
  logic [SW-1:0]                diff_threshold;
  logic                         selective_update;
  logic [CW-1:0]                ghost_limit;
  logic                         cfg_wr;
  rabs_pkg::reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = rabs_pkg::reg_idx_t'(paddr[rabs_pkg::APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= rabs_pkg::MODE_RST;
      alpha_q8         <= rabs_pkg::ALPHA_RST;
      diff_threshold   <= rabs_pkg::THRESH_RST;
      selective_update <= rabs_pkg::SEL_RST;
      ghost_limit      <= rabs_pkg::GHOST_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        rabs_pkg::REG_MODE:    mode             <= pwdata[rabs_pkg::MODE_W-1:0];
        rabs_pkg::REG_ALPHA:   alpha_q8         <= pwdata[rabs_pkg::ALPHA_W-1:0];
        rabs_pkg::REG_THRESH:  diff_threshold   <= pwdata[SW-1:0];
        rabs_pkg::REG_SEL_UPD: selective_update <= pwdata[0];
        rabs_pkg::REG_GHOST:   ghost_limit      <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      rabs_pkg::REG_MODE:    prdata = DW'(mode);
      rabs_pkg::REG_ALPHA:   prdata = DW'(alpha_q8);
      rabs_pkg::REG_THRESH:  prdata = DW'(diff_threshold);
      rabs_pkg::REG_SEL_UPD: prdata = DW'(selective_update);
      rabs_pkg::REG_GHOST:   prdata = DW'(ghost_limit);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- stage valids / flow
  logic [P0-1:0] fv, fkind, f_mv, f_free, f_next_free;
  logic [AW-1:0] fval  [P0];
  logic [SW-1:0] fsamp [P0];
  logic [AW-1:0] red_res [P0];

  logic             v1, v2, v3;
  logic             k1, k2, k3;
  logic [IDX_W-1:0] idx1, idx2, idx3;
  logic [IDX_W-1:0] fidx;
  logic             mv1, mv2, mv3, free1, free2, free3;
  logic             hz, issue_ok, issue;

  assign fidx = IDX_W'(fval[L]);

  // back-to-front advance
  assign mv3   = v3 && (!out_valid || out_ready);
  assign free3 = !v3 || mv3;
  assign mv2   = v2 && free3;
  assign free2 = !v2 || mv2;
  assign mv1   = v1 && free2;
  assign free1 = !v1 || mv1;

  // a process word waits for any older word on its address that is not written back yet
  assign hz = (fkind[L] == rabs_pkg::KIND_PROC) &&
              ((v1 && idx1 == fidx) || (v2 && idx2 == fidx) || (v3 && idx3 == fidx));
  assign issue_ok = free1 && !hz;
  assign issue    = f_mv[L];
  assign in_ready = f_free[0];

  // ---------------------------------------------------------------- address wrap stages
  for (genvar i = 0; i < P0; i++) begin : g_front
    logic [AW-1:0] src;
    logic          load;

    if (i == 0) begin : g_first
      assign src  = sample_addr;
      assign load = in_valid && in_ready;
    end else begin : g_next
      assign src  = fval[i-1];
      assign load = f_mv[i-1];
    end

    if (i == L) begin : g_last
      assign f_next_free[i] = issue_ok;
    end else begin : g_mid
      assign f_next_free[i] = f_free[i+1];
    end

    assign f_mv[i]   = fv[i] && f_next_free[i];
    assign f_free[i] = !fv[i] || f_mv[i];

    // up to four conditional subtracts of the depth shifted into place
    always_comb begin
      logic [RW-1:0] v;
      v = {1'b0, src};
      for (int m = 0; m < rabs_pkg::RED_PER; m++) begin
        if (NSTEP - 1 - rabs_pkg::RED_PER * i - m >= 0) begin
          if (v >= (RW'(NUM_SAMPLES) << (NSTEP - 1 - rabs_pkg::RED_PER * i - m))) begin
            v = v - (RW'(NUM_SAMPLES) << (NSTEP - 1 - rabs_pkg::RED_PER * i - m));
          end
        end
      end
      red_res[i] = v[AW-1:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        fv[i] <= 1'b0;
      end else if (load) begin
        fv[i] <= 1'b1;
      end else if (f_mv[i]) begin
        fv[i] <= 1'b0;
      end
    end

    if (i == 0) begin : g_pay0
      always_ff @(posedge clk) begin
        if (load) begin
          fkind[i] <= kind;
          fsamp[i] <= sample;
          fval[i]  <= red_res[i];
        end
      end
    end else begin : g_payn
      always_ff @(posedge clk) begin
        if (load) begin
          fkind[i] <= fkind[i-1];
          fsamp[i] <= fsamp[i-1];
          fval[i]  <= red_res[i];
        end
      end
    end
  end

  // ---------------------------------------------------------------- store
  // entry = {run count, background}
  logic [CW+SW-1:0] store [NUM_SAMPLES];
  logic [CW+SW-1:0] rdata;
  logic [CW+SW-1:0] wdata;

  always_ff @(posedge clk) begin
    if (issue) begin
      rdata <= store[fidx];
    end
    if (mv3) begin
      store[idx3] <= wdata;
    end
  end

  // ---------------------------------------------------------------- stage 1: multiply
  logic [SW-1:0]                s1;
  logic [rabs_pkg::ALPHA_W-1:0] a_sat, a_cmp;
  logic [PW-1:0]                ps_next, pb_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (issue) begin
      v1 <= 1'b1;
    end else if (mv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      k1   <= fkind[L];
      idx1 <= fidx;
      s1   <= fsamp[L];
    end
  end

  // alpha above one saturates to one
  assign a_sat   = (alpha_q8 > rabs_pkg::ALPHA_ONE) ? rabs_pkg::ALPHA_ONE : alpha_q8;
  assign a_cmp   = rabs_pkg::ALPHA_ONE - a_sat;
  assign ps_next = PW'(a_sat) * PW'(s1);
  assign pb_next = PW'(a_cmp) * PW'(rdata[SW-1:0]);

  // ---------------------------------------------------------------- stage 2: blend, compare
  logic [PW-1:0] ps2, pb2, blend_sum;
  logic [SW-1:0] s2, bg2, bgb_next, diff_next;
  logic [CW-1:0] cnt2;
  logic          fg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (mv1) begin
      v2 <= 1'b1;
    end else if (mv2) begin
      v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      k2   <= k1;
      idx2 <= idx1;
      s2   <= s1;
      ps2  <= ps_next;
      pb2  <= pb_next;
      bg2  <= rdata[SW-1:0];
      cnt2 <= rdata[CW+SW-1:SW];
    end
  end

  // single round-half-up on the Q8.8 blend; the sum never exceeds 16 bits
  assign blend_sum = ps2 + pb2 + rabs_pkg::ROUND_HALF;
  assign bgb_next  = (mode != rabs_pkg::MODE_PLAIN) ? blend_sum[PW-1:SW] : bg2;
  assign diff_next = (s2 >= bgb_next) ? (s2 - bgb_next) : (bgb_next - s2);
  assign fg_next   = diff_next > diff_threshold;

  // ---------------------------------------------------------------- stage 3: update decision
  logic [SW-1:0] s3, bgb3, diff3;
  logic [CW-1:0] cnt3, cnt_up, cnt_fin;
  logic [SW-1:0] bg_fin, diff_fin;
  logic          fg3, fg_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (mv2) begin
      v3 <= 1'b1;
    end else if (mv3) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      k3    <= k2;
      idx3  <= idx2;
      s3    <= s2;
      bgb3  <= bgb_next;
      diff3 <= diff_next;
      fg3   <= fg_next;
      cnt3  <= cnt2;
    end
  end

  assign cnt_up = (cnt3 == rabs_pkg::CNT_MAX) ? cnt3 : cnt3 + 1'b1;

  always_comb begin
    bg_fin   = bgb3;
    cnt_fin  = cnt3;
    fg_fin   = fg3;
    diff_fin = diff3;
    priority if (k3 == rabs_pkg::KIND_INIT) begin
      bg_fin   = s3;
      cnt_fin  = '0;
      fg_fin   = 1'b0;
      diff_fin = '0;
    end else if (mode == rabs_pkg::MODE_RUNAVG) begin
      // selective update: background words take the sample
      if (selective_update && !fg3) begin
        bg_fin = s3;
      end
    end else if (mode != rabs_pkg::MODE_PLAIN) begin
      // ghost counter: absorb a long foreground run
      if (fg3) begin
        cnt_fin = cnt_up;
        if (cnt_up >= ghost_limit) begin
          bg_fin = s3;
        end
      end else begin
        cnt_fin = '0;
      end
    end
  end

  assign wdata = {cnt_fin, bg_fin};

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mv3) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      foreground       <= fg_fin;
      difference       <= diff_fin;
      background_value <= bg_fin;
    end
  end

`ifndef ASSERT_OFF
  // result flag always agrees with the reported difference
  a_fg_matches_diff: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (foreground == (difference > diff_threshold)))
    else $error("foreground flag disagrees with difference");

  // an init word leaves with a zero difference and no foreground
  a_init_result: assert property (@(posedge clk) disable iff (rst)
    (mv3 && k3 == rabs_pkg::KIND_INIT) |=> (out_valid && !foreground && difference == '0))
    else $error("init word produced a nonzero result");

  // an empty pipeline always takes a word
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    (!(|fv) && !v1 && !v2 && !v3) |-> in_ready)
    else $error("empty pipeline not ready");

  // a word stuck in the read stage keeps its address
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !mv1) |=> (v1 && $stable(idx1)))
    else $error("read stage lost or changed a stalled word");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the running-average background subtractor.
`timescale 1ns / 100ps

module tb;

  localparam int ADDR_W      = rabs_pkg::ADDR_W;
  localparam int SAMPLE_W    = rabs_pkg::SAMPLE_W;
  localparam int MODE_W      = rabs_pkg::MODE_W;
  localparam int ALPHA_W     = rabs_pkg::ALPHA_W;
  localparam int CNT_W       = rabs_pkg::CNT_W;
  localparam int APB_AW      = rabs_pkg::APB_AW;
  localparam int APB_DW      = rabs_pkg::APB_DW;

  localparam int HALF_PERIOD = 5;
  localparam int RST_CYCLES  = 7;
  localparam int DRAIN_CYC   = 12;       // pipeline depth plus hazard wait, with margin
  localparam int RUN_LIMIT   = 2000000;  // ns
  localparam int PIX_MAX     = 255;
  localparam int N_PHASES    = 6;
  localparam int PHASE_WORDS = 65;
  localparam int SAT_WORDS   = 260;
  localparam int POOL_SZ     = 6;
  localparam logic [ADDR_W-1:0] ADDR_TOP = {ADDR_W{1'b1}};

  // Mode codes the package leaves unnamed
  localparam logic [MODE_W-1:0] MODE_GHOST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic                fg;
    logic [SAMPLE_W-1:0] diff;
    logic [SAMPLE_W-1:0] bgv;
  } px_result_t;

  typedef enum {ROW_WORD, ROW_REG} row_op_t;

  typedef struct {
    row_op_t            op;
    logic               k;
    logic [ADDR_W-1:0]  a;
    logic [31:0]        v;
    rabs_pkg::reg_idx_t ridx;
    bit                 known;
    px_result_t         want;
  } dir_row_t;

  // DUT connections
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = rabs_pkg::KIND_INIT;
  logic [ADDR_W-1:0]     sample_addr = '0;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  foreground;
  logic [SAMPLE_W-1:0]   difference;
  logic [SAMPLE_W-1:0]   background_value;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  // Shadow registers and per-address state
  logic [MODE_W-1:0]   cfg_mode   = rabs_pkg::MODE_RST;
  logic [ALPHA_W-1:0]  cfg_alpha  = rabs_pkg::ALPHA_RST;
  logic [SAMPLE_W-1:0] cfg_thresh = rabs_pkg::THRESH_RST;
  logic                cfg_sel    = rabs_pkg::SEL_RST;
  logic [CNT_W-1:0]    cfg_ghost  = rabs_pkg::GHOST_RST;
  logic [SAMPLE_W-1:0] bg_mem [int unsigned];
  logic [CNT_W-1:0]    run_mem [int unsigned];

  px_result_t pending_px[$];
  dir_row_t   dir_rows[$];

  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned reg_writes   = 0;
  int unsigned burst_left   = 0;
  int unsigned stall_left   = 0;
  int unsigned stall_style  = 0;
  int unsigned cyc_cnt      = 0;

  logic [MODE_W-1:0] phase_mode [N_PHASES] =
    '{rabs_pkg::MODE_PLAIN, rabs_pkg::MODE_RUNAVG, rabs_pkg::MODE_RUNAVG,
      MODE_GHOST, MODE_SPARE, MODE_GHOST};

  running_average_background_subtractor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .sample_addr(sample_addr), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .foreground(foreground), .difference(difference), .background_value(background_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Background estimate, difference and ghost counter for one word
  function automatic px_result_t subtract_background(logic k, logic [ADDR_W-1:0] a,
                                                     logic [SAMPLE_W-1:0] s);
    px_result_t  r;
    int unsigned bgv, al, d, c;
    logic        hit;
    if (k == rabs_pkg::KIND_INIT) begin
      bg_mem[a]  = s;
      run_mem[a] = '0;
      r.fg   = 1'b0;
      r.diff = '0;
      r.bgv  = s;
      return r;
    end
    bgv = 32'(bg_mem[a]);
    al  = (cfg_alpha > rabs_pkg::ALPHA_ONE) ? 32'(rabs_pkg::ALPHA_ONE) : 32'(cfg_alpha);
    if (cfg_mode != rabs_pkg::MODE_PLAIN)
      bgv = ((al * s + (rabs_pkg::ALPHA_ONE - al) * bgv + rabs_pkg::ROUND_HALF) >> SAMPLE_W)
            & PIX_MAX;
    d   = (s >= bgv) ? s - bgv : bgv - s;
    hit = d > cfg_thresh;
    if (cfg_mode == rabs_pkg::MODE_RUNAVG) begin
      if (cfg_sel && !hit) bgv = 32'(s);
    end else if (cfg_mode != rabs_pkg::MODE_PLAIN) begin
      // modes 2 and 3: consecutive foreground run, absorb at the limit
      c = 32'(run_mem[a]);
      if (hit) begin
        if (c < rabs_pkg::CNT_MAX) c++;
        if (c >= cfg_ghost) bgv = 32'(s);
      end else begin
        c = 0;
      end
      run_mem[a] = c[CNT_W-1:0];
    end
    bg_mem[a] = bgv[SAMPLE_W-1:0];
    r.fg   = hit;
    r.diff = d[SAMPLE_W-1:0];
    r.bgv  = bgv[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_extreme(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // Table builders
  task automatic add_word(logic k, logic [ADDR_W-1:0] a, logic [SAMPLE_W-1:0] s);
    dir_row_t row;
    row = '{op: ROW_WORD, k: k, a: a, v: 32'(s), ridx: rabs_pkg::REG_MODE, known: 1'b0,
            want: '0};
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_known(logic k, logic [ADDR_W-1:0] a, logic [SAMPLE_W-1:0] s,
                           logic fg, logic [SAMPLE_W-1:0] d, logic [SAMPLE_W-1:0] b);
    dir_row_t row;
    row = '{op: ROW_WORD, k: k, a: a, v: 32'(s), ridx: rabs_pkg::REG_MODE, known: 1'b1,
            want: '{fg: fg, diff: d, bgv: b}};
    dir_rows = {dir_rows, row};
  endtask

  task automatic add_reg(rabs_pkg::reg_idx_t ridx, logic [31:0] v);
    dir_row_t row;
    row = '{op: ROW_REG, k: rabs_pkg::KIND_INIT, a: '0, v: v, ridx: ridx, known: 1'b0,
            want: '0};
    dir_rows = {dir_rows, row};
  endtask

  // Config write: setup cycle, then access cycle until pready
  task automatic write_reg(rabs_pkg::reg_idx_t ridx, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (ridx)
      rabs_pkg::REG_MODE:    cfg_mode   = v[MODE_W-1:0];
      rabs_pkg::REG_ALPHA:   cfg_alpha  = v[ALPHA_W-1:0];
      rabs_pkg::REG_THRESH:  cfg_thresh = v[SAMPLE_W-1:0];
      rabs_pkg::REG_SEL_UPD: cfg_sel    = v[0];
      rabs_pkg::REG_GHOST:   cfg_ghost  = v[CNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Sender pacing: bursts of random length, random gaps between
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic send_word(logic k, logic [ADDR_W-1:0] a, logic [SAMPLE_W-1:0] s,
                           bit known, px_result_t want);
    px_result_t pred;
    pace();
    in_valid    <= 1'b1;
    kind        <= k;
    sample_addr <= a;
    sample      <= s;
    do @(posedge clk); while (!in_ready);
    pred = subtract_background(k, a, s);
    pending_px = {pending_px, (known ? want : pred)};
    words_sent++;
  endtask

  // Hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic check_field(string nm, logic [SAMPLE_W-1:0] want, logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin : result_chk
    px_result_t exp_px;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      results_seen++;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result word fg=%0b diff=%0d bg=%0d", $time,
                 foreground, difference, background_value);
        mismatches++;
      end else begin
        exp_px = pending_px.pop_front();
        check_field("foreground", SAMPLE_W'(exp_px.fg), SAMPLE_W'(foreground));
        check_field("difference", exp_px.diff, difference);
        check_field("background_value", exp_px.bgv, background_value);
      end
    end
  end

  // Result-side back-pressure, switching at random among four styles
  always @(posedge clk) begin
    cyc_cnt <= cyc_cnt + 1;
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cyc_cnt[2:0] != 3'd5);
    endcase
  end

  initial begin
    #(RUN_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim
    logic [ADDR_W-1:0]   addr_pool [POOL_SZ];
    logic [ADDR_W-1:0]   a, sat_addr;
    logic [SAMPLE_W-1:0] s;
    logic                k;
    int                  near;

    // Directed table, reset settings first
    add_known(rabs_pkg::KIND_INIT, '0, 8'd0, 1'b0, 8'd0, 8'd0);
    add_known(rabs_pkg::KIND_INIT, ADDR_TOP, 8'd255, 1'b0, 8'd0, 8'd255);
    add_known(rabs_pkg::KIND_PROC, '0, 8'd255, 1'b1, 8'd255, 8'd0);
    add_known(rabs_pkg::KIND_PROC, ADDR_TOP, 8'd0, 1'b1, 8'd255, 8'd255);
    add_known(rabs_pkg::KIND_PROC, ADDR_TOP, 8'd255, 1'b0, 8'd0, 8'd255);
    add_known(rabs_pkg::KIND_INIT, 20'h12345, 8'd100, 1'b0, 8'd0, 8'd100);
    // difference equal to threshold, then one above
    add_known(rabs_pkg::KIND_PROC, 20'h12345, 8'd125, 1'b0, 8'd25, 8'd100);
    add_known(rabs_pkg::KIND_PROC, 20'h12345, 8'd126, 1'b1, 8'd26, 8'd100);
    // alpha of one: background follows the sample
    add_reg(rabs_pkg::REG_MODE, 32'(rabs_pkg::MODE_RUNAVG));
    add_reg(rabs_pkg::REG_ALPHA, 32'(rabs_pkg::ALPHA_ONE));
    add_known(rabs_pkg::KIND_PROC, '0, 8'd200, 1'b0, 8'd0, 8'd200);
    // alpha above one saturates
    add_reg(rabs_pkg::REG_ALPHA, 32'h1FF);
    add_word(rabs_pkg::KIND_PROC, '0, 8'd17);
    add_reg(rabs_pkg::REG_ALPHA, 32'd0);
    add_word(rabs_pkg::KIND_PROC, '0, 8'd0);
    // selective update with zero threshold, then max threshold
    add_reg(rabs_pkg::REG_THRESH, 32'd0);
    add_reg(rabs_pkg::REG_SEL_UPD, 32'd1);
    add_reg(rabs_pkg::REG_ALPHA, 32'd64);
    add_word(rabs_pkg::KIND_PROC, 20'h12345, 8'd90);
    add_word(rabs_pkg::KIND_PROC, 20'h12345, 8'd90);
    add_reg(rabs_pkg::REG_THRESH, 32'd255);
    add_word(rabs_pkg::KIND_PROC, '0, 8'd255);
    // ghost counter: absorb on the second hit, then clear
    add_reg(rabs_pkg::REG_MODE, 32'(MODE_GHOST));
    add_reg(rabs_pkg::REG_GHOST, 32'd2);
    add_reg(rabs_pkg::REG_THRESH, 32'd10);
    add_reg(rabs_pkg::REG_ALPHA, 32'd0);
    add_known(rabs_pkg::KIND_INIT, 20'h00777, 8'd0, 1'b0, 8'd0, 8'd0);
    add_word(rabs_pkg::KIND_PROC, 20'h00777, 8'd200);
    add_word(rabs_pkg::KIND_PROC, 20'h00777, 8'd200);
    add_word(rabs_pkg::KIND_PROC, 20'h00777, 8'd200);
    // zero limit and the spare mode code
    add_reg(rabs_pkg::REG_GHOST, 32'd0);
    add_reg(rabs_pkg::REG_MODE, 32'(MODE_SPARE));
    add_word(rabs_pkg::KIND_PROC, 20'h00777, 8'd0);
    add_word(rabs_pkg::KIND_PROC, 20'h00777, 8'd0);

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_REG) begin
        drain();
        write_reg(dir_rows[i].ridx, dir_rows[i].v);
      end else begin
        send_word(dir_rows[i].k, dir_rows[i].a, dir_rows[i].v[SAMPLE_W-1:0],
                  dir_rows[i].known, dir_rows[i].want);
      end
    end

    // Random phases: new settings each time, small address pool for hazards
    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_reg(rabs_pkg::REG_MODE, 32'(phase_mode[p]));
      write_reg(rabs_pkg::REG_ALPHA, pick_extreme(0, (1 << ALPHA_W) - 1));
      write_reg(rabs_pkg::REG_THRESH, ($urandom_range(0, 2) == 0) ? pick_extreme(0, PIX_MAX)
                                                                  : $urandom_range(0, 60));
      write_reg(rabs_pkg::REG_SEL_UPD, (p == 1) ? 0 : (p == 2) ? 1 : $urandom_range(0, 1));
      write_reg(rabs_pkg::REG_GHOST, ($urandom_range(0, 3) == 0) ? pick_extreme(0, PIX_MAX)
                                                                 : $urandom_range(1, 4));
      addr_pool[0] = '0;
      addr_pool[1] = ADDR_TOP;
      for (int j = 2; j < POOL_SZ; j++) addr_pool[j] = ADDR_W'($urandom_range(0, ADDR_TOP));
      for (int n = 0; n < PHASE_WORDS; n++) begin
        a = addr_pool[$urandom_range(0, POOL_SZ - 1)];
        // never process an address that has not been initialized
        k = (!bg_mem.exists(a) || $urandom_range(0, 9) == 0) ? rabs_pkg::KIND_INIT
                                                              : rabs_pkg::KIND_PROC;
        if (k == rabs_pkg::KIND_PROC && $urandom_range(0, 2) == 0) begin
          // land near the threshold of the current background
          near = int'(bg_mem[a]) + ($urandom_range(0, 1) ? 1 : -1) *
                 (int'(cfg_thresh) + int'($urandom_range(0, 1)));
          s = (near < 0) ? 8'd0 : (near > PIX_MAX) ? 8'd255 : near[SAMPLE_W-1:0];
        end else begin
          s = SAMPLE_W'($urandom_range(0, PIX_MAX));
        end
        send_word(k, a, s, 1'b0, '0);
      end
    end

    // Long foreground run on one address: counter saturates at the max limit
    drain();
    write_reg(rabs_pkg::REG_MODE, 32'(MODE_GHOST));
    write_reg(rabs_pkg::REG_ALPHA, 32'd0);
    write_reg(rabs_pkg::REG_THRESH, 32'd0);
    write_reg(rabs_pkg::REG_GHOST, 32'(rabs_pkg::CNT_MAX));
    write_reg(rabs_pkg::REG_SEL_UPD, $urandom_range(0, 1));
    sat_addr = ADDR_W'($urandom_range(0, ADDR_TOP));
    send_word(rabs_pkg::KIND_INIT, sat_addr, 8'd128, 1'b0, '0);
    for (int n = 0; n < SAT_WORDS; n++) begin
      s = n[0] ? SAMPLE_W'($urandom_range(155, PIX_MAX)) : SAMPLE_W'($urandom_range(0, 100));
      send_word(rabs_pkg::KIND_PROC, sat_addr, s, 1'b0, '0);
    end

    drain();
    $display("Sent %0d words and checked %0d results over %0d register writes,",
             words_sent, results_seen, reg_writes);
    $display("covering all modes, alpha and threshold extremes and counter saturation.");
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
